### rtl/core/qvr_pkg.sv
// Shared types, widths and register map of the quaternion vector rotation block.
package qvr_pkg;

    // Fixed formats of the coordinates and of the quaternion.
    localparam int COORD_WIDTH    = 32;
    localparam int QUAT_WIDTH     = 16;
    localparam int QUAT_FRAC_BITS = 14;

    // Stream word widths: three coordinates packed from the lowest bit, padded to bytes.
    localparam int DATA_W = ((3 * COORD_WIDTH + 7) / 8) * 8;
    localparam int USER_W = 1;

    // Configuration port.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_IDX_W  = 2;

    // Quaternion component products and rotation matrix entries.
    localparam int PROD_W = 2 * QUAT_WIDTH;
    localparam int MAT_W  = (2 * QUAT_WIDTH + 2 > 2 * QUAT_FRAC_BITS + 2) ?
                            2 * QUAT_WIDTH + 2 : 2 * QUAT_FRAC_BITS + 2;

    // Matrix entries are split in two halves for the point multiplications.
    localparam int SPLIT  = MAT_W / 2;
    localparam int PLO_W  = SPLIT + 1 + COORD_WIDTH;
    localparam int PHI_W  = MAT_W - SPLIT + COORD_WIDTH;
    localparam int LSUM_W = PLO_W + 2;
    localparam int HSUM_W = PHI_W + 2;

    // Exact row sum, and the value after dropping the fraction bits.
    localparam int ACC_W = MAT_W + COORD_WIDTH + 2;
    localparam int RND_W = ACC_W - 2 * QUAT_FRAC_BITS;

    // Register map.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUAT_SCALAR = 2'd0,
        REG_QUAT_I      = 2'd1,
        REG_QUAT_J      = 2'd2,
        REG_QUAT_K      = 2'd3
    } t_reg_idx;

    localparam logic [QUAT_WIDTH-1:0] QUAT_SCALAR_RST = 16'd16384;

    // Indexes of the nine quaternion component products.
    localparam int P_II = 0;
    localparam int P_JJ = 1;
    localparam int P_KK = 2;
    localparam int P_IJ = 3;
    localparam int P_IK = 4;
    localparam int P_JK = 5;
    localparam int P_IS = 6;
    localparam int P_JS = 7;
    localparam int P_KS = 8;
    localparam int NUM_PROD = 9;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [QUAT_WIDTH-1:0]  t_quat;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [MAT_W-1:0]       t_mat;
    typedef logic signed [PLO_W-1:0]       t_plo;
    typedef logic signed [PHI_W-1:0]       t_phi;
    typedef logic signed [LSUM_W-1:0]      t_lsum;
    typedef logic signed [HSUM_W-1:0]      t_hsum;
    typedef logic signed [ACC_W-1:0]       t_acc;
    typedef logic signed [RND_W-1:0]       t_rnd;

endpackage

### rtl/core/quaternion_vector_rotate_top.sv
// Quaternion rotation of a stream of 3D points as a five-stage pipeline.
// Throughput: one word per cycle unless the output stalls; multipliers are fully pipelined.
// Each stage advances when it is empty or the next one advances, so bubbles close up on a stall.
// Reset (synchronous, active low) empties the pipeline and loads the identity quaternion.
module quaternion_vector_rotate_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Configuration port.
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [qvr_pkg::CFG_ADDR_W-1:0]         paddr,
    input  logic [qvr_pkg::CFG_DATA_W-1:0]         pwdata,
    output logic [qvr_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                   pready,
    // Input points.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [qvr_pkg::DATA_W-1:0]             s_axis_tdata,  // point_x, point_y, point_z
    // Rotated points.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [qvr_pkg::DATA_W-1:0]             m_axis_tdata,  // rotated_x, rotated_y, rotated_z
    output logic [qvr_pkg::USER_W-1:0]             m_axis_tuser   // clipped
);

    localparam int CW     = qvr_pkg::COORD_WIDTH;
    localparam int QW     = qvr_pkg::QUAT_WIDTH;
    localparam int NSTAGE = 5;
    localparam int PADW   = qvr_pkg::DATA_W - 3 * CW;
    localparam int FRAC2  = 2 * qvr_pkg::QUAT_FRAC_BITS;
    localparam logic [qvr_pkg::MAT_W-1:0] MAT_ONE = qvr_pkg::MAT_W'(1) << FRAC2;
    localparam logic [qvr_pkg::ACC_W-1:0] HALF    = qvr_pkg::ACC_W'(1) << (FRAC2 - 1);
    localparam logic [CW-1:0] COORD_MAX = {1'b0, {(CW - 1){1'b1}}};
    localparam logic [CW-1:0] COORD_MIN = {1'b1, {(CW - 1){1'b0}}};

    // Configuration registers: scalar, i, j, k.
    qvr_pkg::t_quat r_quat [4];

    // Pipeline valid bits and stage load enables.
    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] en;

    // Stage registers.
    qvr_pkg::t_prod  r_s1_prod [qvr_pkg::NUM_PROD];
    qvr_pkg::t_coord r_s1_pt   [3];
    qvr_pkg::t_mat   r_s2_mat  [3][3];
    qvr_pkg::t_coord r_s2_pt   [3];
    qvr_pkg::t_plo   r_s3_plo  [3][3];
    qvr_pkg::t_phi   r_s3_phi  [3][3];
    qvr_pkg::t_lsum  r_s4_lo   [3];
    qvr_pkg::t_hsum  r_s4_hi   [3];
    qvr_pkg::t_coord r_s5_coord [3];
    logic            r_s5_clip;

    // Next values of the stage registers.
    qvr_pkg::t_prod  n_s1_prod [qvr_pkg::NUM_PROD];
    qvr_pkg::t_coord n_s1_pt   [3];
    qvr_pkg::t_mat   n_s2_mat  [3][3];
    qvr_pkg::t_plo   n_s3_plo  [3][3];
    qvr_pkg::t_phi   n_s3_phi  [3][3];
    qvr_pkg::t_lsum  n_s4_lo   [3];
    qvr_pkg::t_hsum  n_s4_hi   [3];
    qvr_pkg::t_coord n_s5_coord [3];
    logic            n_s5_clip;

    logic                           cfg_wr;
    qvr_pkg::t_reg_idx              cfg_idx;

    // ------------------------------------------------------------------
    // Configuration port: writes take effect at the access cycle.
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = qvr_pkg::t_reg_idx'(paddr[qvr_pkg::CFG_IDX_W+1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat[0] <= qvr_pkg::QUAT_SCALAR_RST;
            r_quat[1] <= '0;
            r_quat[2] <= '0;
            r_quat[3] <= '0;
        end else if (cfg_wr) begin
            r_quat[cfg_idx] <= pwdata[QW-1:0];
        end
    end

    // Read data returns the addressed register, zero extended.
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            qvr_pkg::REG_QUAT_SCALAR: prdata[QW-1:0] = r_quat[0];
            qvr_pkg::REG_QUAT_I:      prdata[QW-1:0] = r_quat[1];
            qvr_pkg::REG_QUAT_J:      prdata[QW-1:0] = r_quat[2];
            qvr_pkg::REG_QUAT_K:      prdata[QW-1:0] = r_quat[3];
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage flow control: a stage loads when it is empty or drains.
    // ------------------------------------------------------------------
    always_comb begin
        en[NSTAGE-1] = !r_vld[NSTAGE-1] || m_axis_tready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack the point and form the quaternion component products.
    // ------------------------------------------------------------------
    always_comb begin
        for (int n = 0; n < 3; n++) begin
            n_s1_pt[n] = s_axis_tdata[n*CW +: CW];
        end
        n_s1_prod[qvr_pkg::P_II] = r_quat[1] * r_quat[1];
        n_s1_prod[qvr_pkg::P_JJ] = r_quat[2] * r_quat[2];
        n_s1_prod[qvr_pkg::P_KK] = r_quat[3] * r_quat[3];
        n_s1_prod[qvr_pkg::P_IJ] = r_quat[1] * r_quat[2];
        n_s1_prod[qvr_pkg::P_IK] = r_quat[1] * r_quat[3];
        n_s1_prod[qvr_pkg::P_JK] = r_quat[2] * r_quat[3];
        n_s1_prod[qvr_pkg::P_IS] = r_quat[1] * r_quat[0];
        n_s1_prod[qvr_pkg::P_JS] = r_quat[2] * r_quat[0];
        n_s1_prod[qvr_pkg::P_KS] = r_quat[3] * r_quat[0];
    end

    // ------------------------------------------------------------------
    // Stage 2: build the rotation matrix from twice the products.
    // ------------------------------------------------------------------
    qvr_pkg::t_mat d [qvr_pkg::NUM_PROD];

    always_comb begin
        for (int n = 0; n < qvr_pkg::NUM_PROD; n++) begin
            d[n] = {{(qvr_pkg::MAT_W - qvr_pkg::PROD_W){r_s1_prod[n][qvr_pkg::PROD_W-1]}},
                    r_s1_prod[n]} <<< 1;
        end
        n_s2_mat[0][0] = MAT_ONE - d[qvr_pkg::P_JJ] - d[qvr_pkg::P_KK];
        n_s2_mat[0][1] = d[qvr_pkg::P_IJ] - d[qvr_pkg::P_KS];
        n_s2_mat[0][2] = d[qvr_pkg::P_IK] + d[qvr_pkg::P_JS];
        n_s2_mat[1][0] = d[qvr_pkg::P_IJ] + d[qvr_pkg::P_KS];
        n_s2_mat[1][1] = MAT_ONE - d[qvr_pkg::P_II] - d[qvr_pkg::P_KK];
        n_s2_mat[1][2] = d[qvr_pkg::P_JK] - d[qvr_pkg::P_IS];
        n_s2_mat[2][0] = d[qvr_pkg::P_IK] - d[qvr_pkg::P_JS];
        n_s2_mat[2][1] = d[qvr_pkg::P_JK] + d[qvr_pkg::P_IS];
        n_s2_mat[2][2] = MAT_ONE - d[qvr_pkg::P_II] - d[qvr_pkg::P_JJ];
    end

    // ------------------------------------------------------------------
    // Stage 3: multiply each coordinate by the low and high halves of its entry.
    // ------------------------------------------------------------------
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_s3_plo[r][c] = $signed({1'b0, r_s2_mat[r][c][qvr_pkg::SPLIT-1:0]})
                                 * r_s2_pt[c];
                n_s3_phi[r][c] = $signed(r_s2_mat[r][c][qvr_pkg::MAT_W-1:qvr_pkg::SPLIT])
                                 * r_s2_pt[c];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: sum the low and the high partial products of each row.
    // ------------------------------------------------------------------
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            n_s4_lo[r] = '0;
            n_s4_hi[r] = '0;
            for (int c = 0; c < 3; c++) begin
                n_s4_lo[r] = n_s4_lo[r] +
                    {{(qvr_pkg::LSUM_W - qvr_pkg::PLO_W){r_s3_plo[r][c][qvr_pkg::PLO_W-1]}},
                     r_s3_plo[r][c]};
                n_s4_hi[r] = n_s4_hi[r] +
                    {{(qvr_pkg::HSUM_W - qvr_pkg::PHI_W){r_s3_phi[r][c][qvr_pkg::PHI_W-1]}},
                     r_s3_phi[r][c]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: join the halves, round half up, drop the fraction and saturate.
    // ------------------------------------------------------------------
    qvr_pkg::t_acc acc [3];
    qvr_pkg::t_rnd rnd [3];
    logic [2:0]    ovf;

    always_comb begin
        n_s5_clip = 1'b0;
        for (int r = 0; r < 3; r++) begin
            acc[r] = ({{(qvr_pkg::ACC_W - qvr_pkg::HSUM_W){r_s4_hi[r][qvr_pkg::HSUM_W-1]}},
                       r_s4_hi[r]} <<< qvr_pkg::SPLIT)
                   + {{(qvr_pkg::ACC_W - qvr_pkg::LSUM_W){r_s4_lo[r][qvr_pkg::LSUM_W-1]}},
                      r_s4_lo[r]}
                   + HALF;
            rnd[r] = acc[r][qvr_pkg::ACC_W-1:FRAC2];
            ovf[r] = !((&rnd[r][qvr_pkg::RND_W-1:CW-1]) || !(|rnd[r][qvr_pkg::RND_W-1:CW-1]));
            if (!ovf[r]) begin
                n_s5_coord[r] = rnd[r][CW-1:0];
            end else if (rnd[r][qvr_pkg::RND_W-1]) begin
                n_s5_coord[r] = COORD_MIN;
            end else begin
                n_s5_coord[r] = COORD_MAX;
            end
            n_s5_clip = n_s5_clip | ovf[r];
        end
    end

    // Payload registers of all stages load with their enable.
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s1_prod <= n_s1_prod;
            r_s1_pt   <= n_s1_pt;
        end
        if (en[1]) begin
            r_s2_mat <= n_s2_mat;
            r_s2_pt  <= r_s1_pt;
        end
        if (en[2]) begin
            r_s3_plo <= n_s3_plo;
            r_s3_phi <= n_s3_phi;
        end
        if (en[3]) begin
            r_s4_lo <= n_s4_lo;
            r_s4_hi <= n_s4_hi;
        end
        if (en[4]) begin
            r_s5_coord <= n_s5_coord;
            r_s5_clip  <= n_s5_clip;
        end
    end

    // Output word.
    assign m_axis_tvalid = r_vld[NSTAGE-1];
    generate
        if (PADW > 0) begin : g_pad
            assign m_axis_tdata = {{PADW{1'b0}}, r_s5_coord[2], r_s5_coord[1], r_s5_coord[0]};
        end else begin : g_nopad
            assign m_axis_tdata = {r_s5_coord[2], r_s5_coord[1], r_s5_coord[0]};
        end
    endgenerate
    assign m_axis_tuser = r_s5_clip;

endmodule

### test/qvr_rotation_checker.sv
// Checker that predicts rotated points from the observed bus traffic and compares them.
module qvr_rotation_checker
    import qvr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic                  pready,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [DATA_W-1:0]     s_axis_tdata,  // point_x, point_y, point_z
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [DATA_W-1:0]     m_axis_tdata,  // rotated_x, rotated_y, rotated_z
    input  logic [USER_W-1:0]     m_axis_tuser,  // clipped
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
        logic   clipped;
    } t_rotation;

    localparam int    ROUND_SHIFT = 2 * QUAT_FRAC_BITS;
    localparam t_wide UNITY       = t_wide'(1) <<< ROUND_SHIFT;
    localparam t_wide HALF_LSB    = t_wide'(1) <<< (ROUND_SHIFT - 1);
    localparam t_wide COORD_TOP   = (t_wide'(1) <<< (COORD_WIDTH - 1)) - 1;
    localparam t_wide COORD_BOT   = -(t_wide'(1) <<< (COORD_WIDTH - 1));

    // Shadow copy of the quaternion registers.
    t_quat quat_s = QUAT_SCALAR_RST;
    t_quat quat_i = '0;
    t_quat quat_j = '0;
    t_quat quat_k = '0;

    t_rotation rotations_due [$];
    int        mismatch_count = 0;

    // Rotation matrix built exactly from the quaternion, applied to the point, then each
    // row sum is rounded half up once and saturated to the coordinate range.
    function automatic t_rotation rotate_point(t_quat qs, t_quat qi, t_quat qj, t_quat qk,
                                               t_coord px, t_coord py, t_coord pz);
        t_wide     s, i, j, k;
        t_wide     mat [3][3];
        t_wide     pt [3];
        t_wide     acc;
        t_coord    res [3];
        t_rotation out;
        s = qs;
        i = qi;
        j = qj;
        k = qk;
        pt[0] = px;
        pt[1] = py;
        pt[2] = pz;
        mat[0][0] = UNITY - 2 * j * j - 2 * k * k;
        mat[0][1] = 2 * i * j - 2 * k * s;
        mat[0][2] = 2 * i * k + 2 * j * s;
        mat[1][0] = 2 * i * j + 2 * k * s;
        mat[1][1] = UNITY - 2 * i * i - 2 * k * k;
        mat[1][2] = 2 * j * k - 2 * i * s;
        mat[2][0] = 2 * i * k - 2 * j * s;
        mat[2][1] = 2 * j * k + 2 * i * s;
        mat[2][2] = UNITY - 2 * i * i - 2 * j * j;
        out.clipped = 1'b0;
        for (int r = 0; r < 3; r++) begin
            acc = mat[r][0] * pt[0] + mat[r][1] * pt[1] + mat[r][2] * pt[2];
            acc = (acc + HALF_LSB) >>> ROUND_SHIFT;
            if (acc > COORD_TOP) begin
                acc = COORD_TOP;
                out.clipped = 1'b1;
            end else if (acc < COORD_BOT) begin
                acc = COORD_BOT;
                out.clipped = 1'b1;
            end
            res[r] = acc[COORD_WIDTH-1:0];
        end
        out.x = res[0];
        out.y = res[1];
        out.z = res[2];
        return out;
    endfunction

    task automatic compare_field(string name, logic signed [COORD_WIDTH-1:0] want,
                                 logic signed [COORD_WIDTH-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Track register writes, queue a prediction per accepted point, check each output word.
    always @(posedge i_clk) begin : watch
        t_rotation got;
        t_rotation want;
        t_reg_idx  widx;
        if (!i_rst_n) begin
            quat_s = QUAT_SCALAR_RST;
            quat_i = '0;
            quat_j = '0;
            quat_k = '0;
            rotations_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                widx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
                case (widx)
                    REG_QUAT_SCALAR: quat_s = pwdata[QUAT_WIDTH-1:0];
                    REG_QUAT_I:      quat_i = pwdata[QUAT_WIDTH-1:0];
                    REG_QUAT_J:      quat_j = pwdata[QUAT_WIDTH-1:0];
                    REG_QUAT_K:      quat_k = pwdata[QUAT_WIDTH-1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.x       = m_axis_tdata[COORD_WIDTH-1:0];
                got.y       = m_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
                got.z       = m_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
                got.clipped = m_axis_tuser[0];
                if (rotations_due.size() == 0) begin
                    $error("rotated point word with no input point outstanding");
                    mismatch_count++;
                end else begin
                    want = rotations_due.pop_front();
                    compare_field("rotated_x", want.x, got.x);
                    compare_field("rotated_y", want.y, got.y);
                    compare_field("rotated_z", want.z, got.z);
                    compare_field("clipped", {31'b0, want.clipped}, {31'b0, got.clipped});
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                rotations_due.push_back(rotate_point(
                    quat_s, quat_i, quat_j, quat_k,
                    s_axis_tdata[COORD_WIDTH-1:0],
                    s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH],
                    s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH]));
            end
        end
        o_pending    <= rotations_due.size();
        o_fail_count <= mismatch_count;
    end

endmodule

### test/tb_top.sv
// Top of the quaternion rotation testbench: clock, reset, register writes and point traffic.
module tb_top;
    import qvr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PHASES      = 12;
    localparam int RANDOM_PER_SET  = 48;
    localparam int PIPE_SETTLE     = 8;
    localparam t_coord COORD_MAX   = 32'sh7FFF_FFFF;
    localparam t_coord COORD_MIN   = 32'sh8000_0000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr         = '0;
    logic [CFG_DATA_W-1:0] pwdata        = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_W-1:0]     s_axis_tdata  = '0;  // point_x, point_y, point_z
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_W-1:0]     m_axis_tdata;        // rotated_x, rotated_y, rotated_z
    logic [USER_W-1:0]     m_axis_tuser;        // clipped
    int                    o_fail_count;
    int                    o_pending;

    int burst_left = 0;
    int stall_mode = 0;
    int stall_run  = 0;

    quaternion_vector_rotate_top dut (.*);

    qvr_rotation_checker checker_inst (.*);

    // Free-running clock.
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the pipeline hangs.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Output backpressure: each stretch picks always ready, coin flip, mostly stalled,
    // or mostly ready.
    always @(posedge i_clk) begin
        if (stall_run == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_run  <= $urandom_range(4, 40);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Register write with a setup and an access phase; the register takes the value in the access cycle.
    task automatic write_reg(t_reg_idx idx, t_quat value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sends one point; words go out in bursts with idle gaps between them.
    task automatic send_point(t_coord x, t_coord y, t_coord z);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
    endtask

    // Stops the input stream and waits until every predicted word has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (o_pending != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    task automatic load_quat(t_quat qs, t_quat qi, t_quat qj, t_quat qk);
        write_reg(REG_QUAT_SCALAR, qs);
        write_reg(REG_QUAT_I, qi);
        write_reg(REG_QUAT_J, qj);
        write_reg(REG_QUAT_K, qk);
    endtask

    // Mostly small coordinates, some full-range words and a few extremes.
    function automatic t_coord random_coord();
        logic signed [20:0] near;
        t_coord             c;
        near = 21'($urandom);
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       c = COORD_MAX;
                    1:       c = COORD_MIN;
                    2:       c = '0;
                    3:       c = -1;
                    default: c = 1;
                endcase
            end
            1, 2, 3: c = $urandom;
            default: c = t_coord'(near);
        endcase
        return c;
    endfunction

    // Random quaternion, either close to unit length or raw register contents.
    task automatic random_quat(bit unit_len, output t_quat q [4]);
        real comp [4];
        real norm;
        if (unit_len) begin
            norm = 0.0;
            for (int n = 0; n < 4; n++) begin
                comp[n] = real'(int'($urandom_range(0, 2000)) - 1000);
                norm += comp[n] * comp[n];
            end
            if (norm == 0.0) begin
                comp[0] = 1.0;
                norm    = 1.0;
            end
            norm = $sqrt(norm);
            for (int n = 0; n < 4; n++) q[n] = t_quat'($rtoi(comp[n] / norm * 16384.0));
        end else begin
            for (int n = 0; n < 4; n++) q[n] = t_quat'($urandom);
        end
    endtask

    // Reset, then a series of quaternion settings, each followed by point traffic.
    initial begin
        t_coord corner [6][3];
        t_quat  q [4];
        corner = '{'{COORD_MAX, COORD_MAX, COORD_MAX},
                   '{COORD_MIN, COORD_MIN, COORD_MIN},
                   '{32'sd0, 32'sd0, 32'sd0},
                   '{COORD_MAX, COORD_MIN, 32'sd1},
                   '{32'sd1, 32'sd1, -32'sd1},
                   '{-32'sd1, 32'sd3, -32'sd3}};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                drain();
                case (phase)
                    // Half-length quaternion: two diagonal entries of one half expose rounding ties.
                    1:       q = '{16'sd0, 16'sd8192, 16'sd0, 16'sd0};
                    // Largest components: far from unit length, rows saturate.
                    2:       q = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
                    3:       q = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
                    // Quarter turn about z.
                    4:       q = '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585};
                    5:       q = '{16'sd0, 16'sh8000, 16'sh7FFF, 16'sd0};
                    default: random_quat(phase % 2 == 0, q);
                endcase
                load_quat(q[0], q[1], q[2], q[3]);
            end
            // Corner points under reset, rounding-tie and saturating settings.
            if (phase < 3) begin
                foreach (corner[n]) send_point(corner[n][0], corner[n][1], corner[n][2]);
            end
            repeat (RANDOM_PER_SET) send_point(random_coord(), random_coord(), random_coord());
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (o_fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
